// ===== src/a1_cell_reference_parser_top_assert.svh =====
// assertion macros used by the checker of the a1 cell reference parser
`ifndef A1_CELL_REFERENCE_PARSER_TOP_ASSERT_SVH
`define A1_CELL_REFERENCE_PARSER_TOP_ASSERT_SVH

// same-cycle implication, silent while reset is high
`define A1P_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, silent while reset is high
`define A1P_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/a1p_pkg.sv =====
// constants, widths and shared types of the a1 cell reference parser
`timescale 1ns / 1ps

package a1p_pkg;

   localparam int MAX_ROW_COUNT = 16384;
   localparam int MAX_COL_COUNT = 16384;
   localparam int MAX_LETTERS   = 3;

   localparam int RADIX_COL = 26;
   localparam int RADIX_ROW = 10;

   // field widths of the result word, and the character width
   localparam int POS_W   = 15;
   localparam int CH_W    = 8;
   localparam int RSP_W   = 32;

   // accumulators saturate one above their bound
   localparam int ROW_CAP   = MAX_ROW_COUNT + 1;
   localparam int COL_CAP   = MAX_COL_COUNT + 1;
   localparam int ROW_ACC_W = $clog2(ROW_CAP + 1);
   localparam int COL_ACC_W = $clog2(COL_CAP + 1);
   localparam int ROW_V_W   = $clog2(ROW_CAP * RADIX_ROW + RADIX_ROW);
   localparam int COL_V_W   = $clog2(COL_CAP * RADIX_COL + RADIX_COL + 1);
   localparam int LCNT_W    = $clog2(MAX_LETTERS + 1);

   // character codes
   localparam logic [CH_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CH_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CH_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CH_W-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [CH_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CH_W-1:0] CHAR_NINE    = 8'h39;
   // 'A' - 1, so that A maps to column digit 1
   localparam logic [CH_W-1:0] CHAR_COL_BASE = 8'h40;

   // parse status handed from the scanner to the result stage
   typedef struct packed {
      logic                 fire;
      logic                 bad;
      logic                 has_letters;
      logic                 digit_seen;
      logic [ROW_ACC_W-1:0] row_acc;
      logic [COL_ACC_W-1:0] col_acc;
   } name_end_type;

endpackage

// ===== src/a1p_scan.sv =====
// character scanner: parse state registers and their per-character update
`timescale 1ns / 1ps

module a1p_scan (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [a1p_pkg::CH_W-1:0]            ch,
   input  logic                                last,
   output a1p_pkg::name_end_type               name_end
);

   logic                              in_digits_ff, in_digits_in;
   logic [a1p_pkg::LCNT_W-1:0]        lcnt_ff, lcnt_in;
   logic [a1p_pkg::COL_ACC_W-1:0]     col_ff, col_in;
   logic [a1p_pkg::ROW_ACC_W-1:0]     row_ff, row_in;
   logic                              seen_ff, seen_in;
   logic                              bad_ff, bad_in;

   logic                              is_upper, is_lower, is_digit;
   logic [a1p_pkg::COL_V_W-1:0]       col_v;
   logic [a1p_pkg::ROW_V_W-1:0]       row_v;
   logic [a1p_pkg::COL_ACC_W-1:0]     col_sat;
   logic [a1p_pkg::ROW_ACC_W-1:0]     row_sat;
   logic                              dp_bad, dp_seen;
   logic [a1p_pkg::ROW_ACC_W-1:0]     dp_row;

   assign is_upper = (ch >= a1p_pkg::CHAR_UPPER_A) && (ch <= a1p_pkg::CHAR_UPPER_Z);
   assign is_lower = (ch >= a1p_pkg::CHAR_LOWER_A) && (ch <= a1p_pkg::CHAR_LOWER_Z);
   assign is_digit = (ch >= a1p_pkg::CHAR_ZERO) && (ch <= a1p_pkg::CHAR_NINE);

   // multiply-add with saturation for both accumulators
   assign col_v = a1p_pkg::COL_V_W'(col_ff) * a1p_pkg::COL_V_W'(a1p_pkg::RADIX_COL)
                + a1p_pkg::COL_V_W'(5'(ch - a1p_pkg::CHAR_COL_BASE));
   assign row_v = a1p_pkg::ROW_V_W'(row_ff) * a1p_pkg::ROW_V_W'(a1p_pkg::RADIX_ROW)
                + a1p_pkg::ROW_V_W'(4'(ch - a1p_pkg::CHAR_ZERO));
   assign col_sat = (col_v > a1p_pkg::COL_V_W'(a1p_pkg::COL_CAP))
                  ? a1p_pkg::COL_ACC_W'(a1p_pkg::COL_CAP) : a1p_pkg::COL_ACC_W'(col_v);
   assign row_sat = (row_v > a1p_pkg::ROW_V_W'(a1p_pkg::ROW_CAP))
                  ? a1p_pkg::ROW_ACC_W'(a1p_pkg::ROW_CAP) : a1p_pkg::ROW_ACC_W'(row_v);

   // digit phase outcome, shared by both phases
   assign dp_bad  = bad_ff | ~is_digit | (is_digit & ~seen_ff & (ch == a1p_pkg::CHAR_ZERO));
   assign dp_seen = seen_ff | is_digit;
   assign dp_row  = is_digit ? row_sat : row_ff;

   always_comb begin
      in_digits_in = in_digits_ff;
      lcnt_in      = lcnt_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      seen_in      = seen_ff;
      bad_in       = bad_ff;
      if (!in_digits_ff) begin
         if (is_upper || is_lower) begin
            if (is_lower || (lcnt_ff >= a1p_pkg::LCNT_W'(a1p_pkg::MAX_LETTERS))) begin
               bad_in = 1'b1;
            end else begin
               col_in = col_sat;
            end
            if (lcnt_ff < a1p_pkg::LCNT_W'(a1p_pkg::MAX_LETTERS)) begin
               lcnt_in = lcnt_ff + a1p_pkg::LCNT_W'(1);
            end
         end else begin
            // first non-letter ends the column part
            in_digits_in = 1'b1;
            bad_in       = dp_bad | (lcnt_ff == '0);
            seen_in      = dp_seen;
            row_in       = dp_row;
         end
      end else begin
         bad_in  = dp_bad;
         seen_in = dp_seen;
         row_in  = dp_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && last)) begin
         in_digits_ff <= 1'b0;
         lcnt_ff      <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         seen_ff      <= 1'b0;
         bad_ff       <= 1'b0;
      end else if (accept) begin
         in_digits_ff <= in_digits_in;
         lcnt_ff      <= lcnt_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         seen_ff      <= seen_in;
         bad_ff       <= bad_in;
      end
   end

   assign name_end.fire        = accept & last;
   assign name_end.bad         = bad_in;
   assign name_end.has_letters = (lcnt_in != '0);
   assign name_end.digit_seen  = seen_in;
   assign name_end.row_acc     = row_in;
   assign name_end.col_acc     = col_in;

endmodule

// ===== src/a1p_out.sv =====
// result stage: range check, zero-based conversion and the result register
`timescale 1ns / 1ps

module a1p_out (
   input  logic                          clock,
   input  logic                          reset,
   input  a1p_pkg::name_end_type         name_end,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic [a1p_pkg::RSP_W-1:0]     rsp_tdata,
   output logic                          slot_free
);

   logic                          vld_ff, vld_in;
   logic [a1p_pkg::RSP_W-1:0]     data_ff, data_in;
   logic                          ok;
   logic [a1p_pkg::POS_W-1:0]     row_pos, col_pos;

   assign ok = ~name_end.bad & name_end.has_letters & name_end.digit_seen
             & (name_end.col_acc >= a1p_pkg::COL_ACC_W'(1))
             & (name_end.col_acc <= a1p_pkg::COL_ACC_W'(a1p_pkg::MAX_COL_COUNT))
             & (name_end.row_acc >= a1p_pkg::ROW_ACC_W'(1))
             & (name_end.row_acc <= a1p_pkg::ROW_ACC_W'(a1p_pkg::MAX_ROW_COUNT));

   assign row_pos = ok ? a1p_pkg::POS_W'(name_end.row_acc - a1p_pkg::ROW_ACC_W'(1)) : '1;
   assign col_pos = ok ? a1p_pkg::POS_W'(name_end.col_acc - a1p_pkg::COL_ACC_W'(1)) : '1;

   assign slot_free = ~vld_ff | rsp_tready;

   always_comb begin
      vld_in  = vld_ff & ~rsp_tready;
      data_in = data_ff;
      if (name_end.fire) begin
         vld_in  = 1'b1;
         data_in = {1'b0, col_pos, row_pos, ok};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;

endmodule

// ===== src/a1_cell_reference_parser_top.sv =====
// top level of the a1 cell reference parser
`timescale 1ns / 1ps

// channel  | ports                               | word
// ---------+-------------------------------------+------------------------------------
// req      | req_tvalid req_tready req_tdata     | one character, tlast on the last
//          | req_tlast                           | character of the name
// rsp      | rsp_tvalid rsp_tready rsp_tdata     | one parse result per name
//
// one character per cycle while req_tready is high; each character is folded into the parse
// registers by a single multiply-add and saturate, and a last character writes the result
// register in the same cycle, so a result shows in the cycle after its last character
// reset (synchronous, active high) clears the parse state and empties the result
// register; no result is lost when rsp stalls: req_tready drops only while a result
// is held and rsp_tready is low

module a1_cell_reference_parser_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] ch
   input  logic                           req_tlast,   // last
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [a1p_pkg::RSP_W-1:0]      rsp_tdata    // [0] valid_res, [15:1] row,
                                                       // [30:16] col, [31] zero
);

   a1p_pkg::name_end_type name_end;
   logic                  slot_free;
   logic                  accept;

   // a character is taken whenever the result register can take a result
   assign req_tready = slot_free;
   assign accept     = req_tvalid & slot_free;

   // parse state and per-character update
   a1p_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .ch       (req_tdata),
      .last     (req_tlast),
      .name_end (name_end)
   );

   // range check and result register
   a1p_out u_out (
      .clock      (clock),
      .reset      (reset),
      .name_end   (name_end),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .slot_free  (slot_free)
   );

endmodule

// ===== src/a1p_checker.sv =====
// port-level checker of the a1 cell reference parser, bound to the top level
`timescale 1ns / 1ps
`include "a1_cell_reference_parser_top_assert.svh"

module a1p_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        req_tlast,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [a1p_pkg::RSP_W-1:0]   rsp_tdata
);

   logic in_word;
   logic in_last_word;

   assign in_word      = req_tvalid & req_tready;
   assign in_last_word = in_word & req_tlast;

   // a rejected name carries row and column of all ones
   `A1P_ASSERT_NOW(a_none_ones, rsp_tvalid && !rsp_tdata[0], rsp_tdata[30:1] == '1, "none result not all ones")

   // an accepted name lies inside the grid
   `A1P_ASSERT_NOW(a_pos_range, rsp_tvalid && rsp_tdata[0], (int'(rsp_tdata[15:1]) < a1p_pkg::MAX_ROW_COUNT) && (int'(rsp_tdata[30:16]) < a1p_pkg::MAX_COL_COUNT), "position out of range")

   // input is never held off while no result waits
   `A1P_ASSERT_NOW(a_ready_empty, !rsp_tvalid, req_tready, "input stalled with empty result slot")

   // a last character always yields a result in the next cycle
   `A1P_ASSERT_NEXT(a_last_result, in_last_word, rsp_tvalid, "no result after last character")

endmodule

bind a1_cell_reference_parser_top a1p_checker u_a1p_checker (.*);
